FILE: src/gbe_pkg.sv
`default_nettype none

package gbe_pkg;

    localparam int PIXEL_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int FMT_W       = 2;
    localparam int LOAD_CNT_W  = 7;
    localparam int GROUP_CNT_W = 8;
    localparam int BANK_COUNT  = 4;
    localparam int BANK_DEPTH  = 16;
    localparam int BANK_SEL_W  = $clog2(BANK_COUNT);
    localparam int BANK_ADDR_W = $clog2(BANK_DEPTH);
    localparam int BIT_SEL_W   = $clog2(BYTE_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
    localparam int REG_INDEX_W = 2;

    localparam logic [FMT_W-1:0] FMT_8X16  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_16X16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_16X32 = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [REG_INDEX_W-1:0] REG_GLYPH_FORMAT = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_FG_COLOR     = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_BACK_COLOR   = 2'd2;

    localparam logic [PIXEL_W-1:0] FG_COLOR_RESET   = 16'hFFFF;
    localparam logic [PIXEL_W-1:0] BACK_COLOR_RESET = 16'h0000;

    localparam logic [LOAD_CNT_W-1:0]  MAX_GLYPH_BYTES  = 7'd64;
    localparam logic [GROUP_CNT_W-1:0] MAX_GLYPH_GROUPS = 8'd128;

    // One queued operation: a byte write into one bank or a four-pixel read.
    typedef struct packed {
        logic                   is_pull;
        logic                   not_ready;
        logic                   last;
        logic [BANK_SEL_W-1:0]  bank;
        logic [BANK_ADDR_W-1:0] addr;
        logic [BIT_SEL_W-1:0]   bit_sel;
        logic [BYTE_W-1:0]      data;
    } job_t;

    function automatic logic [LOAD_CNT_W-1:0] total_bytes(input logic [FMT_W-1:0] fmt);
        logic [LOAD_CNT_W-1:0] res;
        case (fmt)
            FMT_8X16:  res = 7'd16;
            FMT_16X16: res = 7'd32;
            default:   res = 7'd64;
        endcase
        return res;
    endfunction

    function automatic logic [GROUP_CNT_W-1:0] total_groups(input logic [FMT_W-1:0] fmt);
        logic [GROUP_CNT_W-1:0] res;
        case (fmt)
            FMT_8X16:  res = 8'd32;
            FMT_16X16: res = 8'd64;
            default:   res = 8'd128;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/gbe_in_if.sv
`default_nettype none

interface gbe_in_if;
    import gbe_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] glyph_byte;

    modport source (output valid, output cmd, output glyph_byte, input ready);
    modport sink   (input valid, input cmd, input glyph_byte, output ready);
endinterface

`default_nettype wire

FILE: src/gbe_out_if.sv
`default_nettype none

interface gbe_out_if;
    import gbe_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_0;
    logic [PIXEL_W-1:0] pixel_1;
    logic [PIXEL_W-1:0] pixel_2;
    logic [PIXEL_W-1:0] pixel_3;
    logic               group_last;
    logic               not_ready;

    modport source (output valid, output pixel_0, output pixel_1, output pixel_2,
                    output pixel_3, output group_last, output not_ready, input ready);
    modport sink   (input valid, input pixel_0, input pixel_1, input pixel_2,
                    input pixel_3, input group_last, input not_ready, output ready);
endinterface

`default_nettype wire

FILE: src/gbe_front.sv
`default_nettype none

module gbe_front
    import gbe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [FMT_W-1:0] glyph_format,
    gbe_in_if.sink                in_ch,
    output job_t                  push_job,
    output logic                  push_valid,
    input  wire logic             push_ready
);

    logic [LOAD_CNT_W-1:0]  bytes_loaded_reg, bytes_loaded_next;
    logic [GROUP_CNT_W-1:0] groups_pulled_reg, groups_pulled_next;

    logic [LOAD_CNT_W-1:0]  tot_bytes;
    logic [GROUP_CNT_W-1:0] tot_groups;
    logic                   accept;
    logic                   complete;
    logic                   drained;
    logic [LOAD_CNT_W-1:0]  load_idx;
    logic [3:0]             load_col;
    logic [1:0]             load_blk;
    logic [4:0]             pull_row;
    logic [1:0]             pull_quad;

    assign tot_bytes  = total_bytes(glyph_format);
    assign tot_groups = total_groups(glyph_format);
    assign complete   = bytes_loaded_reg >= tot_bytes;
    assign drained    = groups_pulled_reg >= tot_groups;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && push_ready;
    assign push_valid  = in_ch.valid;

    // A load on a finished glyph starts over at byte zero.
    assign load_idx = complete ? '0 : bytes_loaded_reg;

    always_comb
    begin
        // Every format other than the two 16-row ones lays out 32 rows.
        if (glyph_format inside {FMT_8X16, FMT_16X16})
        begin
            load_col = load_idx[4:1];
            load_blk = {1'b0, load_idx[0]};
        end
        else
        begin
            load_col = load_idx[5:2];
            load_blk = load_idx[1:0];
        end

        if (glyph_format == FMT_8X16)
        begin
            pull_row  = groups_pulled_reg[5:1];
            pull_quad = {1'b0, groups_pulled_reg[0]};
        end
        else
        begin
            pull_row  = groups_pulled_reg[6:2];
            pull_quad = groups_pulled_reg[1:0];
        end
    end

    always_comb
    begin
        push_job           = '0;
        push_job.is_pull   = (in_ch.cmd == CMD_PULL);
        push_job.data      = in_ch.glyph_byte;
        bytes_loaded_next  = bytes_loaded_reg;
        groups_pulled_next = groups_pulled_reg;
        if (in_ch.cmd == CMD_PULL)
        begin
            push_job.not_ready = !complete || drained;
            push_job.last      = !push_job.not_ready &&
                                 ((groups_pulled_reg + 8'd1) == tot_groups);
            push_job.addr      = {pull_quad, pull_row[4:3]};
            push_job.bit_sel   = pull_row[2:0];
            if (accept && !push_job.not_ready)
            begin
                groups_pulled_next = groups_pulled_reg + 8'd1;
            end
        end
        else
        begin
            push_job.bank = load_col[1:0];
            push_job.addr = {load_col[3:2], load_blk};
            if (accept)
            begin
                bytes_loaded_next = load_idx + 7'd1;
                if (complete)
                begin
                    groups_pulled_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_loaded_reg  <= '0;
            groups_pulled_reg <= '0;
        end
        else
        begin
            bytes_loaded_reg  <= bytes_loaded_next;
            groups_pulled_reg <= groups_pulled_next;
        end
    end

`ifndef SYNTHESIS
    a_bytes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_loaded_reg <= MAX_GLYPH_BYTES)
        else $error("byte counter ran past the largest glyph");

    a_groups_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        groups_pulled_reg <= MAX_GLYPH_GROUPS)
        else $error("group counter ran past the largest glyph");
`endif

endmodule

`default_nettype wire

FILE: src/gbe_queue.sv
`default_nettype none

module gbe_queue
    import gbe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t push_job,
    input  wire logic push_valid,
    output logic      push_ready,
    output job_t      pop_job,
    output logic      pop_valid,
    input  wire logic pop_ready
);

    job_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg != QUEUE_DEPTH[QUEUE_CNT_W-1:0];
    assign pop_valid  = count_reg != '0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_DEPTH[QUEUE_CNT_W-1:0])
        else $error("queue count exceeds its depth");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QUEUE_DEPTH[QUEUE_CNT_W-1:0]) |->
        (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with the count");
`endif

endmodule

`default_nettype wire

FILE: src/gbe_back.sv
`default_nettype none

module gbe_back
    import gbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PIXEL_W-1:0] fg_color,
    input  wire logic [PIXEL_W-1:0] back_color,
    input  wire job_t               job,
    input  wire logic               job_valid,
    output logic                    job_ready,
    gbe_out_if.source               out_ch
);

    // Bank b holds the byte-column slices of every column c with c mod 4 == b,
    // so one group of four adjacent pixels reads one byte from each bank.
    logic [BYTE_W-1:0] bank_mem [BANK_COUNT][BANK_DEPTH];

    logic [BYTE_W-1:0]    rd_reg [BANK_COUNT];
    logic [BIT_SEL_W-1:0] bit_sel_reg;
    logic                 not_ready_reg;
    logic                 last_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 load_pop;
    logic                 pull_pop;
    logic [BANK_COUNT-1:0] lit;

    assign job_ready = !job.is_pull || !out_valid_reg || out_ch.ready;
    assign load_pop  = job_valid && !job.is_pull;
    assign pull_pop  = job_valid && job.is_pull && job_ready;

    always_ff @(posedge clk)
    begin
        if (load_pop)
        begin
            bank_mem[job.bank][job.addr] <= job.data;
        end
        if (pull_pop)
        begin
            for (int b = 0; b < BANK_COUNT; b++)
            begin
                rd_reg[b] <= bank_mem[b][job.addr];
            end
            bit_sel_reg   <= job.bit_sel;
            not_ready_reg <= job.not_ready;
            last_reg      <= job.last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pull_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        for (int b = 0; b < BANK_COUNT; b++)
        begin
            lit[b] = !not_ready_reg && rd_reg[b][bit_sel_reg];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_0    = lit[0] ? fg_color : back_color;
    assign out_ch.pixel_1    = lit[1] ? fg_color : back_color;
    assign out_ch.pixel_2    = lit[2] ? fg_color : back_color;
    assign out_ch.pixel_3    = lit[3] ? fg_color : back_color;
    assign out_ch.group_last = last_reg;
    assign out_ch.not_ready  = not_ready_reg;

endmodule

`default_nettype wire

FILE: src/glyph_bitmap_to_rgb565_expander_unit.sv
// Glyph bitmap expander. Send a glyph as column-major font bytes (cmd 0), then
// issue pulls (cmd 1); each pull returns four RGB565 pixels of the glyph in
// row-major order, set bits in the foreground color and clear bits in the
// background color, with group_last on the final group. A pull before the
// glyph is fully loaded, or after the last group, returns background pixels
// with not_ready set. Loading after a complete glyph starts a new one. The
// block takes one item per clock cycle as long as results are taken: a
// four-entry queue separates command decode from the bitmap banks. A pull's
// result is registered: the transfer writes the queue, and the bank read is
// registered when the pull leaves the queue. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this.
`default_nettype none

module glyph_bitmap_to_rgb565_expander_unit
    import gbe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [REG_INDEX_W-1:0] cfg_index,
    input  wire logic [PIXEL_W-1:0]     cfg_wdata,
    gbe_in_if.sink                      in_ch,
    gbe_out_if.source                   out_ch
);

    logic [FMT_W-1:0]   glyph_format_reg;
    logic [PIXEL_W-1:0] fg_color_reg;
    logic [PIXEL_W-1:0] back_color_reg;

    job_t push_job;
    logic push_valid;
    logic push_ready;
    job_t pop_job;
    logic pop_valid;
    logic pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_format_reg <= FMT_8X16;
            fg_color_reg     <= FG_COLOR_RESET;
            back_color_reg   <= BACK_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GLYPH_FORMAT: glyph_format_reg <= cfg_wdata[FMT_W-1:0];
                REG_FG_COLOR:     fg_color_reg     <= cfg_wdata;
                REG_BACK_COLOR:   back_color_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    gbe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .glyph_format (glyph_format_reg),
        .in_ch        (in_ch),
        .push_job     (push_job),
        .push_valid   (push_valid),
        .push_ready   (push_ready)
    );

    gbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    gbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fg_color   (fg_color_reg),
        .back_color (back_color_reg),
        .job        (pop_job),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
